// ===== sv/sleep_deadline_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sleep deadline queue assertion macros
// Concurrent assertion shorthands used by the queue top level.
// ----------------------------------------------------------------------------
`ifndef SLEEP_DEADLINE_QUEUE_MACROS_SVH
`define SLEEP_DEADLINE_QUEUE_MACROS_SVH

// same-cycle implication
`define SDQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sleep deadline queue check failed");

// next-cycle implication
`define SDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sleep deadline queue check failed");

`endif

// ===== sv/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sleep deadline queue package
// Shared widths, result codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package sdq_pkg;

   localparam int WakeBits   = 63;
   localparam int StatusBits = 3;
   localparam int MaxResults = 16;
   localparam int RunBits    = $clog2(MaxResults + 1);

   typedef enum logic [StatusBits-1:0] {
      ST_QUEUED  = 3'd0,
      ST_IGNORED = 3'd1,
      ST_FULL    = 3'd2,
      ST_WOKEN   = 3'd3,
      ST_IDLE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAKE
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

endpackage

// ===== sv/sdq_cell.sv =====
// ----------------------------------------------------------------------------
// Sleep deadline queue cell
// One queue slot: holds, takes its neighbor's entry or the new entry on insert,
// and takes the next slot's entry on pop.
// ----------------------------------------------------------------------------
module sdq_cell #(
   parameter int ID_BITS = 8
) (
   input  logic                         clock,
   input  sdq_pkg::cell_ctl_type        ctl,
   input  logic                         occupied,
   input  logic                         keep_prev,
   input  logic [sdq_pkg::WakeBits-1:0] ins_wake,
   input  logic [ID_BITS-1:0]           ins_id,
   input  logic [sdq_pkg::WakeBits-1:0] prev_wake,
   input  logic [ID_BITS-1:0]           prev_id,
   input  logic [sdq_pkg::WakeBits-1:0] next_wake,
   input  logic [ID_BITS-1:0]           next_id,
   output logic                         keep,
   output logic [sdq_pkg::WakeBits-1:0] wake,
   output logic [ID_BITS-1:0]           id
);
   import sdq_pkg::*;

   logic [WakeBits-1:0] wake_ff, wake_in;
   logic [ID_BITS-1:0]  id_ff, id_in;

   assign keep = occupied && (wake_ff <= ins_wake);

   always_comb begin
      wake_in = wake_ff;
      id_in   = id_ff;
      if (ctl.insert && !keep) begin
         if (keep_prev) begin
            wake_in = ins_wake;
            id_in   = ins_id;
         end else begin
            wake_in = prev_wake;
            id_in   = prev_id;
         end
      end else if (ctl.pop) begin
         wake_in = next_wake;
         id_in   = next_id;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
      id_ff   <= id_in;
   end

   assign wake = wake_ff;
   assign id   = id_ff;

endmodule

// ===== sv/sleep_deadline_queue.sv =====
// ----------------------------------------------------------------------------
// Sleep deadline queue
// Tick counter plus a chain of cells holding sleeping thread ids sorted by
// wake time; sleep requests insert, ticks pop every due entry of equal time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req       in   req_valid/req_ready    kind, thread_id, sleep_ticks
//  rsp       out  rsp_valid/rsp_ready    status, woken_id, wake_at, now_count, last
//
//  A sleep request is accepted (wake time add), then inserted in S_EXEC, where
//  every cell past the insertion point shifts at once; req_ready returns after it.
//  A tick passes S_EXEC, then S_WAKE once per woken entry beyond the first (up to 16
//  results); each pop shifts the whole chain by one slot.
//  Output stalls hold the sequencer; an output register parts the channels.
//  Reset clears the tick count and entry count; no clearing pass.
// ----------------------------------------------------------------------------
`include "sleep_deadline_queue_macros.svh"

module sleep_deadline_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [7:0]                     req_thread_id,
   input  logic signed [31:0]             req_sleep_ticks,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sdq_pkg::StatusBits-1:0] rsp_status,
   output logic [7:0]                     rsp_woken_id,
   output logic [sdq_pkg::WakeBits-1:0]   rsp_wake_at,
   output logic [sdq_pkg::WakeBits-1:0]   rsp_now_count,
   output logic                           rsp_last
);
   import sdq_pkg::*;

   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   state_type             state_ff, state_in;
   logic                  kind_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [31:0]           raw_ff;
   logic [WakeBits-1:0]   now_ff;
   logic [WakeBits-1:0]   wake_ff;
   logic [WakeBits-1:0]   due_ff, due_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic [RunBits-1:0]    run_ff, run_in;

   logic                  rsp_valid_ff;
   logic [StatusBits-1:0] rsp_status_ff;
   logic [7:0]            rsp_id_ff;
   logic [WakeBits-1:0]   rsp_wake_ff;
   logic [WakeBits-1:0]   rsp_now_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   status_type            emit_status;
   logic [7:0]            emit_id;
   logic [WakeBits-1:0]   emit_wake;
   logic                  emit_last;

   logic                  out_free;
   logic                  accept;
   cell_ctl_type          ctl;
   logic                  pop_last;
   logic [WakeBits-1:0]   due_val;

   logic [WakeBits-1:0]   cell_wake [QUEUE_DEPTH];
   logic [ID_BITS-1:0]    cell_id   [QUEUE_DEPTH];
   logic                  cell_keep [QUEUE_DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic                occ;
         logic                kprev;
         logic [WakeBits-1:0] pw, nw;
         logic [ID_BITS-1:0]  pid, nid;

         assign occ = CountBits'(gi) < count_ff;

         if (gi == 0) begin : g_first
            assign kprev = 1'b0;
            assign pw    = wake_ff;
            assign pid   = id_ff;
         end else begin : g_mid
            assign kprev = cell_keep[gi-1];
            assign pw    = cell_wake[gi-1];
            assign pid   = cell_id[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_lastcell
            assign nw  = cell_wake[gi];
            assign nid = cell_id[gi];
         end else begin : g_inner
            assign nw  = cell_wake[gi+1];
            assign nid = cell_id[gi+1];
         end

         sdq_cell #(.ID_BITS(ID_BITS)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (occ),
            .keep_prev (kprev),
            .ins_wake  (wake_ff),
            .ins_id    (id_ff),
            .prev_wake (pw),
            .prev_id   (pid),
            .next_wake (nw),
            .next_id   (nid),
            .keep      (cell_keep[gi]),
            .wake      (cell_wake[gi]),
            .id        (cell_id[gi])
         );
      end
   endgenerate

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign due_val  = (state_ff == S_EXEC) ? cell_wake[0] : due_ff;
   assign pop_last = (RunBits'(run_ff + 1'b1) == RunBits'(MaxResults)) ||
                     (count_ff == CountBits'(1)) ||
                     (cell_wake[1] != due_val);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      run_in      = run_ff;
      due_in      = due_ff;
      ctl         = '0;
      emit        = 1'b0;
      emit_status = ST_IDLE;
      emit_id     = '0;
      emit_wake   = '0;
      emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               emit = 1'b1;
               if (!kind_ff) begin
                  state_in = S_IDLE;
                  if (raw_ff == '0 || raw_ff[31]) begin
                     emit_status = ST_IGNORED;
                  end else if (count_ff >= CountBits'(QUEUE_DEPTH)) begin
                     emit_status = ST_FULL;
                  end else begin
                     emit_status = ST_QUEUED;
                     emit_wake   = wake_ff;
                     ctl.insert  = 1'b1;
                     count_in    = count_ff + 1'b1;
                  end
               end else if (count_ff != '0 && cell_wake[0] <= now_ff) begin
                  emit_status = ST_WOKEN;
                  emit_id     = 8'(cell_id[0]);
                  emit_wake   = cell_wake[0];
                  emit_last   = pop_last;
                  ctl.pop     = 1'b1;
                  count_in    = count_ff - 1'b1;
                  due_in      = cell_wake[0];
                  run_in      = RunBits'(run_ff + 1'b1);
                  if (pop_last) begin
                     state_in = S_IDLE;
                     run_in   = '0;
                  end else begin
                     state_in = S_WAKE;
                  end
               end else begin
                  emit_status = ST_IDLE;
                  state_in    = S_IDLE;
               end
            end
         end
         S_WAKE: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = ST_WOKEN;
               emit_id     = 8'(cell_id[0]);
               emit_wake   = due_ff;
               emit_last   = pop_last;
               ctl.pop     = 1'b1;
               count_in    = count_ff - 1'b1;
               run_in      = RunBits'(run_ff + 1'b1);
               if (pop_last) begin
                  state_in = S_IDLE;
                  run_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         run_ff       <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_ff   <= run_in;
         if (accept && req_kind) begin
            now_ff <= now_ff + 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      due_ff <= due_in;
      if (accept) begin
         kind_ff <= req_kind;
         id_ff   <= ID_BITS'(req_thread_id);
         raw_ff  <= $unsigned(req_sleep_ticks);
         wake_ff <= now_ff + WakeBits'($unsigned(req_sleep_ticks));
      end
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_id_ff     <= emit_id;
         rsp_wake_ff   <= emit_wake;
         rsp_now_ff    <= now_ff;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_woken_id  = rsp_id_ff;
   assign rsp_wake_at   = rsp_wake_ff;
   assign rsp_now_count = rsp_now_ff;
   assign rsp_last      = rsp_last_ff;

   `SDQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CountBits'(QUEUE_DEPTH))
   `SDQ_ASSERT_SAME(a_sorted, clock, reset, count_ff >= CountBits'(2), cell_wake[0] <= cell_wake[1])
   `SDQ_ASSERT_SAME(a_woken_due, clock, reset, rsp_valid && rsp_status == ST_WOKEN, rsp_wake_at <= rsp_now_count)
   `SDQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

// ===== verif/sleep_deadline_queue_test.sv =====
// ----------------------------------------------------------------------------
// Sleep deadline queue testbench
// Drives sleep requests and ticks through the request channel, keeps its own
// sorted wake schedule and tick count, and checks every response transfer
// field by field in order. Runs directed corner cases, then random phases
// with sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sleep_deadline_queue_test;
   import sdq_pkg::*;

   localparam int QueueDepth = 16;
   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 400;
   localparam int PhaseItems = 19;

   typedef struct {
      status_type  status;
      logic [7:0]  id;
      logic [62:0] wake;
      logic [62:0] now;
      logic        last;
   } wake_result_type;

   class deadline_tracker;
      logic [62:0]      tick_now;
      logic [62:0]      wake_tab[QueueDepth];
      logic [7:0]       id_tab[QueueDepth];
      int               used;
      wake_result_type  due_results[$];
      int               errors;

      function new();
         tick_now = '0;
         used     = 0;
         errors   = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void push_result(status_type st, logic [7:0] id, logic [62:0] wake,
                                logic last);
         wake_result_type r;
         r.status = st;
         r.id     = id;
         r.wake   = wake;
         r.now    = tick_now;
         r.last   = last;
         due_results.push_back(r);
      endfunction

      function void enter_request(logic kind, logic [7:0] tid, logic signed [31:0] ticks);
         logic [62:0] wake;
         logic [62:0] due;
         int          pos;
         int          n;
         if (kind == 1'b0) begin
            if (ticks <= 0) begin
               push_result(ST_IGNORED, '0, '0, 1'b1);
            end else if (used >= QueueDepth) begin
               push_result(ST_FULL, '0, '0, 1'b1);
            end else begin
               wake = tick_now + {31'b0, ticks[31:0]};
               pos = 0;
               while (pos < used && wake_tab[pos] <= wake) pos++;
               for (int j = used; j > pos; j--) begin
                  wake_tab[j] = wake_tab[j-1];
                  id_tab[j]   = id_tab[j-1];
               end
               wake_tab[pos] = wake;
               id_tab[pos]   = tid;
               used++;
               push_result(ST_QUEUED, '0, wake, 1'b1);
            end
         end else begin
            tick_now = tick_now + 63'd1;
            if (used > 0 && wake_tab[0] <= tick_now) begin
               due = wake_tab[0];
               n = 0;
               while (n < used && n < MaxResults && wake_tab[n] == due) n++;
               for (int j = 0; j < n; j++)
                  push_result(ST_WOKEN, id_tab[j], due, (j + 1 == n));
               for (int j = n; j < used; j++) begin
                  wake_tab[j-n] = wake_tab[j];
                  id_tab[j-n]   = id_tab[j];
               end
               used -= n;
            end else begin
               push_result(ST_IDLE, '0, '0, 1'b1);
            end
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
      endtask

      task match_result(logic [2:0] status, logic [7:0] id, logic [62:0] wake,
                        logic [62:0] now, logic last);
         wake_result_type want;
         if (due_results.size() == 0) begin
            report_mismatch("transfer with nothing pending (status)", status, 0);
            return;
         end
         want = due_results.pop_front();
         if (status !== want.status) report_mismatch("status", status, want.status);
         if (id !== want.id)         report_mismatch("woken_id", id, want.id);
         if (wake !== want.wake)     report_mismatch("wake_at", wake, want.wake);
         if (now !== want.now)       report_mismatch("now_count", now, want.now);
         if (last !== want.last)     report_mismatch("last", last, want.last);
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_kind = 1'b0;
   logic [7:0]              req_thread_id = '0;
   logic signed [31:0]      req_sleep_ticks = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [StatusBits-1:0]   rsp_status;
   logic [7:0]              rsp_woken_id;
   logic [WakeBits-1:0]     rsp_wake_at;
   logic [WakeBits-1:0]     rsp_now_count;
   logic                    rsp_last;

   logic                    rsp_hold = 1'b0;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   int                      cycle_count = 0;
   deadline_tracker         tracker = new();

   sleep_deadline_queue uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_thread_id   (req_thread_id),
      .req_sleep_ticks (req_sleep_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_woken_id    (rsp_woken_id),
      .rsp_wake_at     (rsp_wake_at),
      .rsp_now_count   (rsp_now_count),
      .rsp_last        (rsp_last)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_result(rsp_status, rsp_woken_id, rsp_wake_at, rsp_now_count,
                              rsp_last);
   end

   task send_item(logic kind, logic [7:0] tid, logic signed [31:0] ticks);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_thread_id   <= tid;
      req_sleep_ticks <= ticks;
      do @(posedge clock); while (!req_ready);
      tracker.enter_request(kind, tid, ticks);
   endtask

   task send_random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         send_item(1'b1, 8'($urandom_range(255)), $urandom());
      else if (pick < 90)
         send_item(1'b0, 8'($urandom_range(255)), 32'($urandom_range(12, 1)));
      else if (pick < 94)
         send_item(1'b0, 8'($urandom_range(255)), '0);
      else
         send_item(1'b0, 8'($urandom_range(255)), {1'b1, 31'($urandom())});
   endtask

   task drain_results();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // nothing due yet, then nonpositive durations
      send_item(1'b1, 8'h00, '0);
      send_item(1'b0, 8'hFF, 32'sd0);
      send_item(1'b0, 8'h5A, 32'hFFFF_FFFF);
      send_item(1'b0, 8'hC3, 32'h8000_0000);
      // fill with one wake time, overflow once, then wake the full run
      for (int i = 0; i < QueueDepth; i++)
         send_item(1'b0, 8'(i * 17), 32'sd3);
      send_item(1'b0, 8'hA5, 32'h7FFF_FFFF);
      repeat (3) send_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
      // longest duration; stays queued for the rest of the run
      send_item(1'b0, 8'hFF, 32'h7FFF_FFFF);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               fork
                  begin
                     rsp_hold <= 1'b1;
                     repeat (HoldCycles) @(posedge clock);
                     rsp_hold <= 1'b0;
                  end
               join_none
            end
            1: begin
               send_idle_pct  = 55;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 55;
            end
            default: begin
               send_idle_pct  = 18;
               recv_stall_pct = 18;
            end
         endcase
         repeat (PhaseItems) send_random_item();
         drain_results();
      end

      repeat (50) @(posedge clock);
      if (tracker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
